// ----- rtl/trwc_pkg.sv -----
// ----------------------------------------------------------------------------
// trwc_pkg
// Shared types and constants for the timestamped ring window capture block.
// ----------------------------------------------------------------------------
package trwc_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int TS_W    = 64;
    localparam int DATA_W  = 32;
    localparam int SPAN_W  = 32;
    localparam int FILL_W  = 7;
    localparam int TOTAL_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_RESET   = 2'd2,
        CMD_STATS   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [TS_W-1:0]     entry_ts;
        logic [DATA_W-1:0]   entry_data;
        logic [TS_W-1:0]     event_time;
        logic [SPAN_W-1:0]   pre_us;
        logic [SPAN_W-1:0]   post_us;
    } t_in_item;

    typedef struct packed {
        logic [TS_W-1:0]     item_ts;
        logic [DATA_W-1:0]   item_data;
        logic                item_valid;
        logic                last;
        logic [FILL_W-1:0]   fill_count;
        logic [TOTAL_W-1:0]  total_pushed;
    } t_out_item;

endpackage

// ----- rtl/trwc_ram.sv -----
// ----------------------------------------------------------------------------
// trwc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trwc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/timestamped_ring_window_capture.sv -----
// ----------------------------------------------------------------------------
// timestamped_ring_window_capture
// Overwrite-oldest ring of timestamped entries with time-window readout.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Push, reset and
// stats items leave busy low, so pushes can stream every cycle. A stats
// item strobes its result in the cycle right after acceptance, so it is taken
// on the next edge. An extract holds busy until its walk has finished: the
// ring is held in a single RAM whose output comes from a registered
// read, and the walk reads one entry per cycle from oldest to newest. Results
// are single-cycle pulses on o_strobe and cannot be held off by the receiver;
// they must be captured on the edge that ends the strobe cycle. A matching
// entry is presented one match later (or at the end of the walk) so that the
// last flag can be set on the final one. The RAM is never cleared: entries
// outside the fill count are never read.
// ----------------------------------------------------------------------------
module timestamped_ring_window_capture
    import trwc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = FW + 1;            // room for head + DEPTH
    localparam int MW = TS_W + DATA_WIDTH; // RAM word: {ts, data}

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    // control
    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [FW-1:0]       r_fill, n_fill;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [FW-1:0]       r_left, n_left;
    logic                r_rd_vld, n_rd_vld;
    logic                r_pend_vld, n_pend_vld;
    logic                r_out_vld, n_out_vld;

    // payload
    logic [TS_W-1:0]     r_lo, n_lo;
    logic [TS_W-1:0]     r_hi, n_hi;
    logic [TS_W-1:0]     r_pend_ts, n_pend_ts;
    logic [DATA_W-1:0]   r_pend_data, n_pend_data;
    t_out_item           r_out, n_out;

    // RAM port signals
    logic                ram_we;
    logic                ram_re;
    logic [MW-1:0]       ram_wdata;
    logic [MW-1:0]       ram_rdata;

    logic                accept;
    logic [TS_W:0]       hi_sum;
    logic [SW-1:0]       tail_w;
    logic [TS_W-1:0]     rd_ts;
    logic [DATA_W-1:0]   rd_data;
    logic                rd_match;
    logic                issue;

    assign accept    = start && !busy;
    assign busy      = (r_state != ST_IDLE);
    assign ram_we    = accept && (i_item.cmd == CMD_PUSH);
    assign ram_wdata = {i_item.entry_ts, DATA_WIDTH'(i_item.entry_data)};
    assign issue     = (r_state == ST_SCAN) && (r_left != '0);
    assign ram_re    = issue;

    assign rd_ts    = ram_rdata[DATA_WIDTH +: TS_W];
    assign rd_data  = DATA_W'(ram_rdata[DATA_WIDTH-1:0]);
    assign rd_match = (rd_ts >= r_lo) && (rd_ts <= r_hi);

    // saturating window end, oldest-entry index
    assign hi_sum = {1'b0, i_item.event_time} + (TS_W + 1)'(i_item.post_us);
    always_comb begin
        if (SW'(r_head) >= SW'(r_fill)) begin
            tail_w = SW'(r_head) - SW'(r_fill);
        end else begin
            tail_w = SW'(r_head) + SW'(DEPTH) - SW'(r_fill);
        end
    end

    trwc_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_total     = r_total;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_rd_vld    = 1'b0;
        n_pend_vld  = r_pend_vld;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pend_ts   = r_pend_ts;
        n_pend_data = r_pend_data;
        n_out_vld   = 1'b0;
        n_out       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_item.cmd)
                        CMD_PUSH: begin
                            n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                            n_fill  = (r_fill == FW'(DEPTH)) ? r_fill : r_fill + 1'b1;
                            n_total = r_total + 1'b1;
                        end
                        CMD_RESET: begin
                            n_head  = '0;
                            n_fill  = '0;
                            n_total = '0;
                        end
                        CMD_STATS: begin
                            n_out_vld        = 1'b1;
                            n_out.last       = 1'b1;
                            n_out.fill_count = FILL_W'(r_fill);
                            n_out.total_pushed = r_total;
                        end
                        CMD_EXTRACT: begin
                            n_lo = (i_item.event_time > TS_W'(i_item.pre_us))
                                 ? i_item.event_time - TS_W'(i_item.pre_us) : '0;
                            n_hi = hi_sum[TS_W] ? '1 : hi_sum[TS_W-1:0];
                            n_ptr      = AW'(tail_w);
                            n_left     = r_fill;
                            n_pend_vld = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // read stage: one entry per cycle
                if (issue) begin
                    n_ptr    = (r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                    n_left   = r_left - 1'b1;
                    n_rd_vld = 1'b1;
                end
                // compare stage: a new match releases the held one
                if (r_rd_vld && rd_match) begin
                    if (r_pend_vld) begin
                        n_out_vld        = 1'b1;
                        n_out.item_ts    = r_pend_ts;
                        n_out.item_data  = r_pend_data;
                        n_out.item_valid = 1'b1;
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_ts   = rd_ts;
                    n_pend_data = rd_data;
                end
                // walk finished: flush held match with last, or empty marker
                if (!issue && !r_rd_vld) begin
                    n_out_vld  = 1'b1;
                    n_out.last = 1'b1;
                    if (r_pend_vld) begin
                        n_out.item_ts    = r_pend_ts;
                        n_out.item_data  = r_pend_data;
                        n_out.item_valid = 1'b1;
                    end
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_total    <= '0;
            r_ptr      <= '0;
            r_left     <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_fill     <= n_fill;
            r_total    <= n_total;
            r_ptr      <= n_ptr;
            r_left     <= n_left;
            r_rd_vld   <= n_rd_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_pend_ts   <= n_pend_ts;
        r_pend_data <= n_pend_data;
        r_out       <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule
